/* rtl/triangle_unit_face_normal_unit_assert.svh */
// Assertion macros for the face normal unit
`ifndef TRIANGLE_UNIT_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_UNIT_FACE_NORMAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");
`define TFN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("check failed");
`else
`define TFN_ASSERT_ALWAYS(label, clk, rst, cond)
`define TFN_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/tfn_pkg.sv */
package tfn_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int MW = 31;           // normalized magnitude width
  localparam int SW = 64;           // sum of squares width
  localparam int RW = 32;           // root width
  localparam int QW = 17;           // quotient width
  localparam int NW = 48;           // numerator width
  localparam int OW = 18;           // output component width
  localparam int SQ_STAGES = RW;
  localparam int DIV_STAGES = QW;
  localparam logic [QW-1:0] ONE_Q = QW'(65536);

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               deg;
  } side_t;

  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [RW-1:0]      len;
    logic [2:0]         neg;
    logic               deg;
  } div_t;
endpackage

/* rtl/triangle_unit_face_normal_unit.sv */
// Unit face normal of a triangle given as three Q16.16 vertices. One triangle is accepted
// every cycle while the pipeline does not hold; on its way to the output it passes 57
// register stages: 7 stages for edges, cross product, normalizing shift and sum of
// squares, 32 stages of the integer square root (one root bit per stage) and 17 stages of
// the three divisions (one quotient bit per stage), plus the output register. The whole
// pipeline holds while the output beat is not taken.
// A zero cross product gives a zero normal with the degenerate flag set.
module triangle_unit_face_normal_unit #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z, 32 bits each
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x, normal_y, normal_z (18 bits each), 2 zero bits
  output logic [55:0]  m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser
);
  import tfn_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2*CW + 2;           // product width
  localparam int XW = 2*CW + 2;           // cross magnitude width
  localparam int TW = $clog2(XW + 1);
  localparam int NST = 7 + SQ_STAGES + DIV_STAGES + 1;

  logic           en;
  logic [NST-1:0] vld;

  assign en = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // stage 1: edges
  logic signed [CW:0] e0 [3];
  logic signed [CW:0] e1 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0[i] <= (CW+1)'($signed(s_axis_tdata[(3+i)*32 +: CW]))
               - (CW+1)'($signed(s_axis_tdata[i*32 +: CW]));
        e1[i] <= (CW+1)'($signed(s_axis_tdata[(6+i)*32 +: CW]))
               - (CW+1)'($signed(s_axis_tdata[(3+i)*32 +: CW]));
      end
    end
  end

  // stage 2: products
  logic signed [PW-1:0] pp [3];
  logic signed [PW-1:0] pq [3];
  always_ff @(posedge clk) begin
    if (en) begin
      pp[0] <= PW'(e0[1]) * PW'(e1[2]);
      pq[0] <= PW'(e0[2]) * PW'(e1[1]);
      pp[1] <= PW'(e0[2]) * PW'(e1[0]);
      pq[1] <= PW'(e0[0]) * PW'(e1[2]);
      pp[2] <= PW'(e0[0]) * PW'(e1[1]);
      pq[2] <= PW'(e0[1]) * PW'(e1[0]);
    end
  end

  // stage 3: cross components as sign and magnitude
  logic [XW-1:0] cm [3];
  logic [2:0]    cn3;
  logic signed [PW:0] diff [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pp[i][PW-1], pp[i]} - {pq[i][PW-1], pq[i]};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cn3[i] <= diff[i][PW];
        cm[i]  <= diff[i][PW] ? XW'(-diff[i]) : XW'(diff[i]);
      end
    end
  end

  // stage 4: bit length of the largest magnitude
  logic [XW-1:0] cm4 [3];
  logic [2:0]    cn4;
  logic [TW-1:0] top;
  logic [TW-1:0] top_next;
  logic [XW-1:0] cor;
  always_comb begin
    cor = cm[0] | cm[1] | cm[2];
    top_next = '0;
    for (int b = 0; b < XW; b++) begin
      if (cor[b]) top_next = TW'(b + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cm4 <= cm;
      cn4 <= cn3;
      top <= top_next;
    end
  end

  // stage 5: bring the largest magnitude into [2^30, 2^31)
  side_t s5;
  logic [XW+MW-1:0] wide [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (top > TW'(MW)) wide[i] = {{MW{1'b0}}, cm4[i]} >> (top - TW'(MW));
      else wide[i] = {{MW{1'b0}}, cm4[i]} << (TW'(MW) - top);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s5.m[i] <= wide[i][MW-1:0];
      s5.neg <= cn4;
      s5.deg <= (top == '0);
    end
  end

  // stage 6: squares
  side_t s6;
  logic [2*MW-1:0] sq [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s6 <= s5;
      for (int i = 0; i < 3; i++) sq[i] <= (2*MW)'(s5.m[i]) * (2*MW)'(s5.m[i]);
    end
  end

  // stage 7: sum of squares
  side_t s7;
  logic [SW-1:0] ssum;
  always_ff @(posedge clk) begin
    if (en) begin
      s7 <= s6;
      ssum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    end
  end

  // square root, one root bit per stage
  side_t             sd [SQ_STAGES+1];
  logic [SW-1:0]     sv [SQ_STAGES+1];
  logic [RW-1:0]     rt [SQ_STAGES+1];
  logic [RW+2:0]     rr [SQ_STAGES+1];
  assign sd[0] = s7;
  assign sv[0] = ssum;
  assign rt[0] = '0;
  assign rr[0] = '0;

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    assign cur   = {rr[j][RW:0], sv[j][SW-1-2*j -: 2]};
    assign trial = {1'b0, rt[j], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        sv[j+1] <= sv[j];
        if (cur >= trial) begin
          rr[j+1] <= cur - trial;
          rt[j+1] <= {rt[j][RW-2:0], 1'b1};
        end else begin
          rr[j+1] <= cur;
          rt[j+1] <= {rt[j][RW-2:0], 1'b0};
        end
      end
    end
  end

  // division setup
  div_t dv [DIV_STAGES+1];
  always_comb begin
    dv[0].len = rt[SQ_STAGES];
    dv[0].neg = sd[SQ_STAGES].neg;
    dv[0].deg = sd[SQ_STAGES].deg;
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] = {1'b0, sd[SQ_STAGES].m[i], 16'b0} + NW'(rt[SQ_STAGES] >> 1);
      dv[0].q[i]   = '0;
    end
  end

  // long division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int QB = QW - 1 - j;
    logic [NW-1:0] dsh;
    div_t          dnx;
    assign dsh = NW'(dv[j].len) << QB;
    always_comb begin
      dnx = dv[j];
      for (int i = 0; i < 3; i++) begin
        if (dv[j].rem[i] >= dsh) begin
          dnx.rem[i]   = dv[j].rem[i] - dsh;
          dnx.q[i][QB] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dnx;
      end
    end
  end

  // output register: clamp, apply sign, zero a degenerate normal
  logic [OW-1:0] nrm [3];
  logic          odeg;
  logic [QW-1:0] qc  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv[DIV_STAGES].q[i] > ONE_Q) ? ONE_Q : dv[DIV_STAGES].q[i];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      odeg <= dv[DIV_STAGES].deg;
      for (int i = 0; i < 3; i++) begin
        if (dv[DIV_STAGES].deg) nrm[i] <= '0;
        else if (dv[DIV_STAGES].neg[i]) nrm[i] <= -{1'b0, qc[i]};
        else nrm[i] <= {1'b0, qc[i]};
      end
    end
  end

  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = {2'b00, nrm[2], nrm[1], nrm[0]};
  assign m_axis_tuser  = odeg;

`include "triangle_unit_face_normal_unit_assert.svh"

  `TFN_ASSERT_ALWAYS(a_ready_follows_out, clk, rst,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `TFN_ASSERT_IMPLY(a_deg_zero, clk, rst,
    m_axis_tvalid && m_axis_tuser, m_axis_tdata[53:0] == 54'd0)
  `TFN_ASSERT_IMPLY(a_nondeg_nonzero, clk, rst,
    m_axis_tvalid && !m_axis_tuser, m_axis_tdata[53:0] != 54'd0)

endmodule
